### rtl/md5ds_pkg.sv
// ----------------------------------------------------------------------------
// md5ds_pkg
// Shared types, constants and round functions of the MD5 digest stream.
// ----------------------------------------------------------------------------
package md5ds_pkg;

	typedef logic [31:0]       word_t;
	typedef logic [3:0][31:0]  chain_t;

	localparam word_t INIT_A = 32'h6745_2301;
	localparam word_t INIT_B = 32'hefcd_ab89;
	localparam word_t INIT_C = 32'h98ba_dcfe;
	localparam word_t INIT_D = 32'h1032_5476;

	localparam logic [3:0] LEN_LO_IDX  = 4'd14;
	localparam logic [3:0] LEN_HI_IDX  = 4'd15;
	localparam logic [5:0] LAST_ROUND  = 6'd63;
	localparam logic [2:0] FULL_WORD   = 3'd4;
	localparam word_t      PAD_MARK    = 32'h0000_0080;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ROUND,
		S_PAD,
		S_FIN
	} seq_state_t;

	typedef struct packed {
		logic start;
		logic clear;
	} rnd_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} rnd_sts_t;

	function automatic word_t md5ds_k(input logic [5:0] i);
		word_t k;
		case (i)
			6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
			default: k = '0;
		endcase
		return k;
	endfunction

	function automatic logic [4:0] md5ds_shift(input logic [5:0] i);
		logic [4:0] s;
		case ({i[5:4], i[1:0]})
			4'h0: s = 5'd7;   4'h1: s = 5'd12;  4'h2: s = 5'd17;  4'h3: s = 5'd22;
			4'h4: s = 5'd5;   4'h5: s = 5'd9;   4'h6: s = 5'd14;  4'h7: s = 5'd20;
			4'h8: s = 5'd4;   4'h9: s = 5'd11;  4'ha: s = 5'd16;  4'hb: s = 5'd23;
			4'hc: s = 5'd6;   4'hd: s = 5'd10;  4'he: s = 5'd15;  4'hf: s = 5'd21;
			default: s = '0;
		endcase
		return s;
	endfunction

	// message word index per round, mod 16
	function automatic logic [3:0] md5ds_msg_idx(input logic [5:0] i);
		logic [3:0] j;
		logic [3:0] g;
		j = i[3:0];
		case (i[5:4])
			2'd0:    g = j;
			2'd1:    g = 4'((j << 2) + j + 4'd1);
			2'd2:    g = 4'((j << 1) + j + 4'd5);
			default: g = 4'((j << 3) - j);
		endcase
		return g;
	endfunction

	function automatic word_t md5ds_fun(input logic [1:0] grp, input word_t b,
		input word_t c, input word_t d);
		word_t f;
		case (grp)
			2'd0:    f = (b & c) | (~b & d);
			2'd1:    f = (d & b) | (~d & c);
			2'd2:    f = b ^ c ^ d;
			default: f = c ^ (b | ~d);
		endcase
		return f;
	endfunction

	function automatic word_t md5ds_rotl(input word_t x, input logic [4:0] s);
		logic [63:0] t;
		t = {x, x} << s;
		return t[63:32];
	endfunction

endpackage

### rtl/md5ds_if.sv
// ----------------------------------------------------------------------------
// md5ds_if
// Valid/ready channels of the MD5 digest stream: message words in, digests out.
// ----------------------------------------------------------------------------
interface md5ds_msg_if;
	logic        valid;
	logic        ready;
	logic [31:0] msg_word;
	logic [2:0]  n_bytes;
	logic        last_word;

	modport source(output valid, output msg_word, output n_bytes, output last_word,
		input ready);
	modport sink(input valid, input msg_word, input n_bytes, input last_word,
		output ready);
endinterface

interface md5ds_dig_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_a;
	logic [31:0] digest_b;
	logic [31:0] digest_c;
	logic [31:0] digest_d;

	modport source(output valid, output digest_a, output digest_b, output digest_c,
		output digest_d, input ready);
	modport sink(input valid, input digest_a, input digest_b, input digest_c,
		input digest_d, output ready);
endinterface

### rtl/md5_digest_stream.sv
// ----------------------------------------------------------------------------
// md5_digest_stream
// Streaming MD5: gathers message words, pads the message, returns the digest.
// ----------------------------------------------------------------------------
// Words are taken one per cycle into a 16-word block buffer while the block is
// idle. The 16th word of a block starts compression, which runs through a
// single round datapath: 64 rounds and one chaining add, during which no word
// is taken. After the word flagged last the block writes the padding and the
// 64-bit bit count one word a cycle, into the same block when the count fits;
// otherwise it pads that block out, runs one more compression and writes the
// count into an extra block. Then the digest is loaded into the output register.
// The next message may start while the digest still waits to be taken.
module md5_digest_stream (
	input  logic         clk,
	input  logic         arst_n,
	md5ds_msg_if.sink    msg,
	md5ds_dig_if.source  digest
);
	import md5ds_pkg::*;

	seq_state_t  state_q;
	seq_state_t  state_nx;
	logic [3:0]  wi_q;
	logic        pad80_q;
	logic        len_done_q;
	logic        padding_q;
	logic [60:0] byte_cnt_q;
	word_t       buf_q [16];

	logic        dig_valid_q;
	word_t       dig_a_q;
	word_t       dig_b_q;
	word_t       dig_c_q;
	word_t       dig_d_q;

	rnd_ctl_t    rctl;
	rnd_sts_t    rsts;
	logic [3:0]  rd_idx;
	chain_t      chain;

	logic        accept;
	logic        fin_load;
	logic        buf_we;
	word_t       buf_wdata;
	logic [2:0]  n_eff;
	word_t       last_data;
	word_t       pad_data;

	md5ds_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (rctl),
		.sts      (rsts),
		.msg_idx  (rd_idx),
		.msg_data (buf_q[rd_idx]),
		.chain    (chain)
	);

	assign accept = msg.valid && msg.ready;

	always_comb begin
		n_eff = (!msg.last_word || msg.n_bytes > FULL_WORD) ? FULL_WORD : msg.n_bytes;
		case (n_eff)
			3'd0:    last_data = PAD_MARK;
			3'd1:    last_data = {16'h0, 8'h80, msg.msg_word[7:0]};
			3'd2:    last_data = {8'h0, 8'h80, msg.msg_word[15:0]};
			3'd3:    last_data = {8'h80, msg.msg_word[23:0]};
			default: last_data = msg.msg_word;
		endcase
		// length words only once the 0x80 marker sits behind us
		if (pad80_q) begin
			pad_data = PAD_MARK;
		end else if (wi_q == LEN_LO_IDX) begin
			pad_data = {byte_cnt_q[28:0], 3'b000};
		end else if (wi_q == LEN_HI_IDX && len_done_q) begin
			pad_data = byte_cnt_q[60:29];
		end else begin
			pad_data = '0;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (wi_q == LEN_HI_IDX) begin
						state_nx = S_ROUND;
					end else if (msg.last_word) begin
						state_nx = S_PAD;
					end
				end
			end
			S_PAD: begin
				if (wi_q == LEN_HI_IDX) begin
					state_nx = S_ROUND;
				end
			end
			S_ROUND: begin
				if (rsts.done) begin
					if (len_done_q) begin
						state_nx = S_FIN;
					end else if (padding_q) begin
						state_nx = S_PAD;
					end else begin
						state_nx = S_IDLE;
					end
				end
			end
			S_FIN: begin
				if (!dig_valid_q || digest.ready) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		msg.ready  = 1'b0;
		buf_we     = 1'b0;
		buf_wdata  = pad_data;
		fin_load   = 1'b0;
		case (state_q)
			S_IDLE: begin
				msg.ready = 1'b1;
				buf_we    = accept;
				buf_wdata = msg.last_word ? last_data : msg.msg_word;
			end
			S_PAD: begin
				buf_we = 1'b1;
			end
			S_FIN: begin
				fin_load = !dig_valid_q || digest.ready;
			end
			default: begin
				buf_we = 1'b0;
			end
		endcase
		rctl.start = buf_we && (wi_q == LEN_HI_IDX);
		rctl.clear = fin_load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wi_q        <= '0;
			pad80_q     <= 1'b0;
			len_done_q  <= 1'b0;
			padding_q   <= 1'b0;
			byte_cnt_q  <= '0;
			dig_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (buf_we) begin
				wi_q <= wi_q + 4'd1;
			end
			if (accept) begin
				byte_cnt_q <= byte_cnt_q + 61'(n_eff);
				if (msg.last_word) begin
					padding_q <= 1'b1;
					pad80_q   <= (n_eff == FULL_WORD);
				end
			end
			if (state_q == S_PAD) begin
				pad80_q <= 1'b0;
				if (!pad80_q && wi_q == LEN_LO_IDX) begin
					len_done_q <= 1'b1;
				end
			end
			if (fin_load) begin
				padding_q   <= 1'b0;
				len_done_q  <= 1'b0;
				byte_cnt_q  <= '0;
				dig_valid_q <= 1'b1;
			end else if (digest.ready) begin
				dig_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (buf_we) begin
			buf_q[wi_q] <= buf_wdata;
		end
		if (fin_load) begin
			dig_a_q <= chain[0];
			dig_b_q <= chain[1];
			dig_c_q <= chain[2];
			dig_d_q <= chain[3];
		end
	end

	assign digest.valid    = dig_valid_q;
	assign digest.digest_a = dig_a_q;
	assign digest.digest_b = dig_b_q;
	assign digest.digest_c = dig_c_q;
	assign digest.digest_d = dig_d_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rctl.start |-> !rsts.busy)
		else $error("compression started while round unit busy");

	a_done_in_round: assert property (@(posedge clk) disable iff (!arst_n)
		rsts.done |-> state_q == S_ROUND)
		else $error("round unit finished outside round state");

	a_fin_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN |-> wi_q == '0 && !pad80_q)
		else $error("digest stage reached with partial block");

	a_fin_shows: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |=> digest.valid)
		else $error("digest not presented after load");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		fin_load |-> !digest.valid || digest.ready)
		else $error("pending digest overwritten");

endmodule

### rtl/md5ds_round.sv
// ----------------------------------------------------------------------------
// md5ds_round
// One MD5 round per cycle over a shared datapath; holds the chaining words.
// ----------------------------------------------------------------------------
module md5ds_round (
	input  logic                clk,
	input  logic                arst_n,
	input  md5ds_pkg::rnd_ctl_t ctl,
	output md5ds_pkg::rnd_sts_t sts,
	output logic [3:0]          msg_idx,
	input  md5ds_pkg::word_t    msg_data,
	output md5ds_pkg::chain_t   chain
);
	import md5ds_pkg::*;

	logic       busy_q;
	logic       add_q;
	logic [5:0] rnd_q;
	chain_t     st_q;     // [0]=a [1]=b [2]=c [3]=d
	chain_t     chain_q;

	word_t f;
	word_t sum;
	word_t new_b;

	assign msg_idx = md5ds_msg_idx(rnd_q);

	always_comb begin
		f     = md5ds_fun(rnd_q[5:4], st_q[1], st_q[2], st_q[3]);
		sum   = st_q[0] + f + md5ds_k(rnd_q) + msg_data;
		new_b = st_q[1] + md5ds_rotl(sum, md5ds_shift(rnd_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			add_q   <= 1'b0;
			rnd_q   <= '0;
			st_q    <= '0;
			chain_q <= {INIT_D, INIT_C, INIT_B, INIT_A};
		end else begin
			add_q <= busy_q && !ctl.start && (rnd_q == LAST_ROUND);
			if (ctl.start) begin
				st_q   <= chain_q;
				rnd_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				st_q  <= {st_q[2], st_q[1], new_b, st_q[3]};
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == LAST_ROUND) begin
					busy_q <= 1'b0;
				end
			end
			if (add_q) begin
				for (int i = 0; i < 4; i++) begin
					chain_q[i] <= chain_q[i] + st_q[i];
				end
			end
			if (ctl.clear) begin
				chain_q <= {INIT_D, INIT_C, INIT_B, INIT_A};
			end
		end
	end

	assign sts.busy = busy_q | add_q;
	assign sts.done = add_q;
	assign chain    = chain_q;

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Streams messages into md5_digest_stream and checks every digest it returns
// against a bit-accurate MD5 computed alongside, with random stalls on both
// channels, a long digest back-pressure hold and a full drain mid-run.
// ----------------------------------------------------------------------------
module tb;
	import md5ds_pkg::*;

	localparam int CYCLE_LIMIT = 300000;
	localparam int TAIL_CYCLES = 200;
	localparam int HOLD_CYCLES = 2500;

	localparam word_t ROUND_K [64] = '{
		32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
		32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
		32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
		32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
		32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
		32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
		32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
		32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
		32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
		32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
		32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
		32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
		32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
		32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
		32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
		32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
	};

	localparam int ROT_AMT [16] = '{
		7, 12, 17, 22,  5, 9, 14, 20,  4, 11, 16, 23,  6, 10, 15, 21
	};

	class digest_tracker;
		word_t      chain [4];
		word_t      blk [16];
		logic [60:0] msg_bytes;
		logic [5:0] fill;
		chain_t     want_digests [$];
		int         errors;

		function new();
			errors = 0;
			restart();
		endfunction

		function void restart();
			chain = '{INIT_A, INIT_B, INIT_C, INIT_D};
			msg_bytes = '0;
			fill = '0;
		endfunction

		function void compress_block();
			word_t a, b, c, d, f, t;
			int g, s;
			a = chain[0];
			b = chain[1];
			c = chain[2];
			d = chain[3];
			for (int i = 0; i < 64; i++) begin
				case (i >> 4)
					0: begin
						f = (b & c) | (~b & d);
						g = i;
					end
					1: begin
						f = (d & b) | (~d & c);
						g = 5 * i + 1;
					end
					2: begin
						f = b ^ c ^ d;
						g = 3 * i + 5;
					end
					default: begin
						f = c ^ (b | ~d);
						g = 7 * i;
					end
				endcase
				s = ROT_AMT[((i >> 4) << 2) + (i & 3)];
				t = a + f + ROUND_K[i] + blk[g & 15];
				t = (t << s) | (t >> (32 - s));
				a = d;
				d = c;
				c = b;
				b = b + t;
			end
			chain[0] += a;
			chain[1] += b;
			chain[2] += c;
			chain[3] += d;
		endfunction

		function void push_byte(logic [7:0] v);
			if (fill[1:0] == 2'd0)
				blk[fill[5:2]] = {24'd0, v};
			else
				blk[fill[5:2]][8 * fill[1:0] +: 8] = v;
			fill = fill + 6'd1;
			if (fill == 6'd0)
				compress_block();
		endfunction

		// one accepted request on the message channel
		function void take_word(word_t w, logic [2:0] n, logic last);
			int cnt;
			logic [63:0] bits;
			chain_t dg;
			cnt = (n > FULL_WORD || !last) ? 4 : int'(n);
			for (int i = 0; i < cnt; i++)
				push_byte(w[8 * i +: 8]);
			msg_bytes = msg_bytes + 61'(cnt);
			if (!last)
				return;
			push_byte(8'h80);
			while (fill != 6'd56)
				push_byte(8'h00);
			bits = {msg_bytes, 3'b000};
			for (int i = 0; i < 8; i++)
				push_byte(bits[8 * i +: 8]);
			for (int i = 0; i < 4; i++)
				dg[i] = chain[i];
			want_digests.push_back(dg);
			restart();
		endfunction

		function void check_digest(word_t a, word_t b, word_t c, word_t d);
			chain_t exp_dg;
			word_t got [4];
			string fld [4];
			got = '{a, b, c, d};
			fld = '{"digest_a", "digest_b", "digest_c", "digest_d"};
			if (want_digests.size() == 0) begin
				$error("digest %h %h %h %h with no request waiting", a, b, c, d);
				errors++;
				return;
			end
			exp_dg = want_digests.pop_front();
			for (int i = 0; i < 4; i++) begin
				if (got[i] !== exp_dg[i]) begin
					$error("%s: expected %h, actual %h", fld[i], exp_dg[i], got[i]);
					errors++;
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int unsigned cycles;
	int digests_taken;
	bit steady_tx;
	bit held;

	digest_tracker tracker = new();

	md5ds_msg_if msg();
	md5ds_dig_if dig();

	md5_digest_stream dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg),
		.digest (dig)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && dig.valid === 1'b1 && dig.ready === 1'b1) begin
			tracker.check_digest(dig.digest_a, dig.digest_b, dig.digest_c, dig.digest_d);
			digests_taken <= digests_taken + 1;
		end
	end

	// digest side: random stalls, one long hold, then a stretch always ready
	initial begin
		dig.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && digests_taken >= 12) begin
				held = 1'b1;
				dig.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				dig.ready <= 1'b1;
			end else if (digests_taken >= 25 && digests_taken < 40) begin
				dig.ready <= 1'b1;
			end else begin
				dig.ready <= ($urandom_range(99) >= 30);
			end
		end
	end

	task automatic send_word(input word_t w, input logic [2:0] n, input logic last);
		if (!steady_tx && $urandom_range(99) < 30) begin
			msg.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < 30);
		end
		msg.valid     <= 1'b1;
		msg.msg_word  <= w;
		msg.n_bytes   <= n;
		msg.last_word <= last;
		do @(posedge clk); while (msg.ready !== 1'b1);
		tracker.take_word(w, n, last);
	endtask

	function automatic word_t pick_word();
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		return $urandom;
	endfunction

	task automatic send_message(input int len, output int sent);
		logic [2:0] n;
		for (int i = 0; i < len - 1; i++) begin
			// short counts mid-message are widened to four by the block
			n = ($urandom_range(99) < 15) ? 3'($urandom_range(7)) : FULL_WORD;
			send_word(pick_word(), n, 1'b0);
		end
		send_word(pick_word(), 3'($urandom_range(7)), 1'b1);
		sent = len;
	endtask

	initial begin
		int words_sent;
		int msgs;
		int len;
		int r;
		int sent;
		arst_n        <= 1'b0;
		msg.valid     <= 1'b0;
		msg.msg_word  <= '0;
		msg.n_bytes   <= '0;
		msg.last_word <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, "abc", count overflow, lone byte
		send_word(32'h1234_5678, 3'd0, 1'b1);
		send_word(32'h0063_6261, 3'd3, 1'b1);
		send_word(32'hffff_ffff, 3'd7, 1'b1);
		send_word(32'hffff_ffff, 3'd1, 1'b1);
		send_word(32'h0000_0000, 3'd0, 1'b0);
		send_word(32'ha5a5_5a5a, 3'd5, 1'b1);
		// 56 bytes: length no longer fits, padding spills into a second block
		for (int i = 0; i < 14; i++)
			send_word((i % 2) ? 32'h0000_0000 : 32'hffff_ffff,
				(i < 8) ? 3'(i) : FULL_WORD, i == 13);

		words_sent = 0;
		msgs = 0;
		while (words_sent < 450 || msgs < 36) begin
			steady_tx = (msgs >= 5 && msgs < 15);
			if (msgs == 20) begin
				msg.valid <= 1'b0;
				do @(posedge clk); while (tracker.want_digests.size() != 0);
			end
			r = $urandom_range(99);
			if (r < 55)
				len = $urandom_range(6, 1);
			else if (r < 85)
				len = $urandom_range(18, 7);
			else if (r < 98)
				len = $urandom_range(40, 19);
			else
				len = $urandom_range(100, 60);
			send_message(len, sent);
			words_sent += sent;
			msgs++;
		end
		steady_tx = 1'b0;
		msg.valid <= 1'b0;

		do @(posedge clk); while (tracker.want_digests.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
